// ===== hdl/bsti_pkg.sv =====
// Package for the bucketed sorted table: sizes, table entry types and the
// control store (microcode) of the insert sequencer.
// Depends on nothing; used by bucketed_sorted_table_insert.
`default_nettype none

package bsti_pkg;

  // Table geometry. NUM_BUCKETS is a power of two: the bucket index is the
  // low bits of the shifted id.
  localparam int unsigned NUM_BUCKETS  = 512;
  localparam int unsigned TABLE_DEPTH  = 2048;
  localparam int unsigned BUCKET_SHIFT = 6;

  // Field widths
  localparam int unsigned ID_W     = 15;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned KEY_W    = 16;
  localparam int unsigned REF_W    = 16;
  localparam int unsigned STATUS_W = 2;

  // Derived widths
  localparam int unsigned BKT_W  = $clog2(NUM_BUCKETS);
  localparam int unsigned EIDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned TOT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CNT_W  = TOT_W;
  localparam int unsigned SUM_W  = TOT_W + 1;
  localparam int unsigned K_W    = (TOT_W > $clog2(NUM_BUCKETS + 1)) ?
                                   TOT_W : $clog2(NUM_BUCKETS + 1);

  // Directory entry: count of entries in the bucket and its first index
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] start;
  } dir_t;

  // Table entry
  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [KEY_W-1:0]  id;
    logic [REF_W-1:0]  refs;
  } ent_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND    = 2'd0,
    ST_INSERTED = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  // Sequencer steps (control store addresses)
  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_DIR,
    S_RD,
    S_CMP,
    S_EQ,
    S_HIT,
    S_MISS,
    S_FULL,
    S_DPRIME,
    S_DSWEEP,
    S_EPRIME,
    S_ESHIFT,
    S_ENEW
  } step_e;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_DIR_CLR,
    OP_LATCH,
    OP_LOAD_DIR,
    OP_ENT_RD,
    OP_SCAN_INC,
    OP_ENT_INC,
    OP_LATCH_POS,
    OP_DIR_PRIME,
    OP_DIR_SWEEP,
    OP_ENT_PRIME,
    OP_ENT_SHIFT,
    OP_ENT_NEW
  } op_e;

  // Jump conditions
  typedef enum logic [3:0] {
    C_ALWAYS,
    C_CLR_END,
    C_START,
    C_DIR_EMPTY,
    C_SCAN_END,
    C_ID_LT,
    C_ID_EQ,
    C_FULL,
    C_SWEEP_END,
    C_NO_SHIFT,
    C_SHIFT_END
  } cond_e;

  // One control word
  typedef struct packed {
    op_e     op;
    cond_e   cond;
    step_e   t_true;
    step_e   t_false;
    logic    emit;
    status_e status;
  } ctrl_t;

  function automatic ctrl_t uw(input op_e op, input cond_e cd, input step_e tt,
                               input step_e tf, input logic em, input status_e st);
    ctrl_t c;
    c.op      = op;
    c.cond    = cd;
    c.t_true  = tt;
    c.t_false = tf;
    c.emit    = em;
    c.status  = st;
    return c;
  endfunction

  // Control store: one word per step
  function automatic ctrl_t ucode(input step_e s);
    ctrl_t c;
    unique case (s)
      S_CLR:    c = uw(OP_DIR_CLR,   C_CLR_END,   S_IDLE,   S_CLR,    1'b0, ST_FOUND);
      S_IDLE:   c = uw(OP_LATCH,     C_START,     S_DIR,    S_IDLE,   1'b0, ST_FOUND);
      S_DIR:    c = uw(OP_LOAD_DIR,  C_DIR_EMPTY, S_MISS,   S_RD,     1'b0, ST_FOUND);
      S_RD:     c = uw(OP_ENT_RD,    C_SCAN_END,  S_MISS,   S_CMP,    1'b0, ST_FOUND);
      S_CMP:    c = uw(OP_SCAN_INC,  C_ID_LT,     S_RD,     S_EQ,     1'b0, ST_FOUND);
      S_EQ:     c = uw(OP_NONE,      C_ID_EQ,     S_HIT,    S_MISS,   1'b0, ST_FOUND);
      S_HIT:    c = uw(OP_ENT_INC,   C_ALWAYS,    S_IDLE,   S_IDLE,   1'b1, ST_FOUND);
      S_MISS:   c = uw(OP_LATCH_POS, C_FULL,      S_FULL,   S_DPRIME, 1'b0, ST_FOUND);
      S_FULL:   c = uw(OP_NONE,      C_ALWAYS,    S_IDLE,   S_IDLE,   1'b1, ST_FULL);
      S_DPRIME: c = uw(OP_DIR_PRIME, C_ALWAYS,    S_DSWEEP, S_DSWEEP, 1'b0, ST_FOUND);
      S_DSWEEP: c = uw(OP_DIR_SWEEP, C_SWEEP_END, S_EPRIME, S_DSWEEP, 1'b0, ST_FOUND);
      S_EPRIME: c = uw(OP_ENT_PRIME, C_NO_SHIFT,  S_ENEW,   S_ESHIFT, 1'b0, ST_FOUND);
      S_ESHIFT: c = uw(OP_ENT_SHIFT, C_SHIFT_END, S_ENEW,   S_ESHIFT, 1'b0, ST_FOUND);
      S_ENEW:   c = uw(OP_ENT_NEW,   C_ALWAYS,    S_IDLE,   S_IDLE,   1'b1, ST_INSERTED);
      default:  c = uw(OP_NONE,      C_ALWAYS,    S_IDLE,   S_IDLE,   1'b0, ST_FOUND);
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/bucketed_sorted_table_insert.sv =====
// Bucketed sorted table with reference counts: microcoded sequencer,
// bucket directory memory and entry memory.
// Depends on bsti_pkg.
`default_nettype none

// Usage
// A request (entry_id_i, entry_address_i) transfers at a rising edge with
// start high and busy low. Exactly one result follows: status_o is valid
// for the single cycle in which done_o is high; the receiver cannot stall.
// status: found (count incremented), inserted, or table full.
// After reset the block sweeps the bucket directory to zero, one entry per
// cycle (all NUM_BUCKETS = 512 entries), with busy high; then it takes requests.
// A lookup reads the bucket's directory entry, then scans its entries (at most
// 64) in order. An insert then sweeps the whole bucket directory (one directory
// port pair, one entry per cycle) and moves the entries at and above the
// insertion point up by one (one entry memory port pair, one entry per cycle).
// One request at a time; busy drops in the cycle the result is shown, so the
// next request may transfer while done_o is high.

module bucketed_sorted_table_insert (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [bsti_pkg::ID_W-1:0]     entry_id_i,
  input  logic [bsti_pkg::ADDR_W-1:0]   entry_address_i,
  output logic                          done_o,
  output logic [bsti_pkg::STATUS_W-1:0] status_o
);
  import bsti_pkg::*;

  // Sequencer
  step_e step_q, step_d;
  ctrl_t cw;
  logic  cond;

  // Memories and their ports
  dir_t             dir_mem [NUM_BUCKETS];
  ent_t             ent_mem [TABLE_DEPTH];
  dir_t             dir_rd_q;
  ent_t             ent_rd_q;
  logic             dir_we, dir_re, ent_we, ent_re;
  logic [BKT_W-1:0] dir_waddr, dir_raddr;
  logic [EIDX_W-1:0] ent_waddr, ent_raddr;
  dir_t             dir_wdata;
  ent_t             ent_wdata;

  // Datapath registers
  logic [ID_W-1:0]   id_q, id_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [BKT_W-1:0]  bkt_q, bkt_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [TOT_W-1:0]  base_q, base_d;
  logic [TOT_W-1:0]  i_q, i_d;
  logic [TOT_W-1:0]  pos_q, pos_d;
  logic [TOT_W-1:0]  total_q, total_d;
  logic [K_W-1:0]    k_q, k_d;
  logic              done_q, done_d;
  status_e           status_q, status_d;

  // Shared values
  logic [SUM_W-1:0]  sum;
  logic [K_W-1:0]    km1, km2;
  logic [TOT_W-1:0]  total_m1;
  logic [BKT_W-1:0]  bkt_in;
  logic              id_lt, id_eq, dir_empty;

  assign sum       = {1'b0, base_q} + {1'b0, i_q};
  assign km1       = k_q - K_W'(1);
  assign km2       = k_q - K_W'(2);
  assign total_m1  = total_q - TOT_W'(1);
  assign bkt_in    = BKT_W'(entry_id_i >> BUCKET_SHIFT);
  assign id_lt     = ent_rd_q.id < KEY_W'(id_q);
  assign id_eq     = ent_rd_q.id == KEY_W'(id_q);
  assign dir_empty = dir_rd_q.count == '0;

  // Control word fetch and jump condition
  always_comb begin
    cw = ucode(step_q);
    unique case (cw.cond)
      C_ALWAYS:    cond = 1'b1;
      C_CLR_END:   cond = k_q == K_W'(NUM_BUCKETS - 1);
      C_START:     cond = start;
      C_DIR_EMPTY: cond = dir_empty;
      C_SCAN_END:  cond = !((i_q < cnt_q) && (sum < SUM_W'(TABLE_DEPTH)));
      C_ID_LT:     cond = id_lt;
      C_ID_EQ:     cond = id_eq;
      C_FULL:      cond = total_q >= TOT_W'(TABLE_DEPTH);
      C_SWEEP_END: cond = k_q == K_W'(NUM_BUCKETS);
      C_NO_SHIFT:  cond = pos_q == total_q;
      C_SHIFT_END: cond = k_q == (K_W'(pos_q) + K_W'(1));
      default:     cond = 1'b1;
    endcase
    step_d = cond ? cw.t_true : cw.t_false;
  end

  // Datapath driven by the control word
  always_comb begin
    id_d      = id_q;
    addr_d    = addr_q;
    bkt_d     = bkt_q;
    cnt_d     = cnt_q;
    base_d    = base_q;
    i_d       = i_q;
    pos_d     = pos_q;
    total_d   = total_q;
    k_d       = k_q;
    done_d    = cw.emit;
    status_d  = cw.status;
    dir_we    = 1'b0;
    dir_re    = 1'b0;
    dir_waddr = '0;
    dir_raddr = '0;
    dir_wdata = '0;
    ent_we    = 1'b0;
    ent_re    = 1'b0;
    ent_waddr = '0;
    ent_raddr = '0;
    ent_wdata = '0;
    unique case (cw.op)
      OP_NONE: ;
      // Zero one directory entry after reset
      OP_DIR_CLR: begin
        dir_we    = 1'b1;
        dir_waddr = k_q[BKT_W-1:0];
        k_d       = k_q + K_W'(1);
      end
      // Take the request, fetch its bucket
      OP_LATCH: begin
        if (start) begin
          id_d      = entry_id_i;
          addr_d    = entry_address_i;
          bkt_d     = bkt_in;
          dir_re    = 1'b1;
          dir_raddr = bkt_in;
        end
      end
      // Empty bucket starts at the end of the table
      OP_LOAD_DIR: begin
        cnt_d  = dir_rd_q.count;
        base_d = dir_empty ? total_q : dir_rd_q.start;
        i_d    = '0;
      end
      OP_ENT_RD: begin
        ent_re    = 1'b1;
        ent_raddr = sum[EIDX_W-1:0];
      end
      OP_SCAN_INC: begin
        if (id_lt) begin
          i_d = i_q + TOT_W'(1);
        end
      end
      // Hit: count up, wraps at 16 bits
      OP_ENT_INC: begin
        ent_we         = 1'b1;
        ent_waddr      = sum[EIDX_W-1:0];
        ent_wdata      = ent_rd_q;
        ent_wdata.refs = ent_rd_q.refs + REF_W'(1);
      end
      // Insertion point, clamped to the table end
      OP_LATCH_POS: begin
        pos_d = (sum > {1'b0, total_q}) ? total_q : sum[TOT_W-1:0];
      end
      OP_DIR_PRIME: begin
        dir_re    = 1'b1;
        dir_raddr = '0;
        k_d       = K_W'(1);
      end
      // Write back entry k-1 while reading entry k
      OP_DIR_SWEEP: begin
        dir_we    = 1'b1;
        dir_waddr = km1[BKT_W-1:0];
        if (km1[BKT_W-1:0] == bkt_q) begin
          dir_wdata.count = cnt_q + CNT_W'(1);
          dir_wdata.start = base_q;
        end else begin
          dir_wdata.count = dir_rd_q.count;
          dir_wdata.start = (dir_rd_q.start > base_q) ?
                            dir_rd_q.start + CNT_W'(1) : dir_rd_q.start;
        end
        dir_re    = 1'b1;
        dir_raddr = k_q[BKT_W-1:0];
        k_d       = k_q + K_W'(1);
      end
      OP_ENT_PRIME: begin
        ent_re    = 1'b1;
        ent_raddr = total_m1[EIDX_W-1:0];
        k_d       = K_W'(total_q);
      end
      // Move entry k-1 to k, read k-2, walking down
      OP_ENT_SHIFT: begin
        ent_we    = 1'b1;
        ent_waddr = k_q[EIDX_W-1:0];
        ent_wdata = ent_rd_q;
        ent_re    = 1'b1;
        ent_raddr = km2[EIDX_W-1:0];
        k_d       = km1;
      end
      OP_ENT_NEW: begin
        ent_we            = 1'b1;
        ent_waddr         = pos_q[EIDX_W-1:0];
        ent_wdata.address = addr_q;
        ent_wdata.id      = KEY_W'(id_q);
        ent_wdata.refs    = REF_W'(1);
        total_d           = total_q + TOT_W'(1);
      end
      default: ;
    endcase
  end

  // Step counter and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= S_CLR;
      k_q      <= '0;
      total_q  <= '0;
      done_q   <= 1'b0;
      status_q <= ST_FOUND;
    end else begin
      step_q   <= step_d;
      k_q      <= k_d;
      total_q  <= total_d;
      done_q   <= done_d;
      status_q <= status_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    addr_q <= addr_d;
    bkt_q  <= bkt_d;
    cnt_q  <= cnt_d;
    base_q <= base_d;
    i_q    <= i_d;
    pos_q  <= pos_d;
  end

  // Bucket directory memory
  always_ff @(posedge clk_i) begin
    if (dir_we) begin
      dir_mem[dir_waddr] <= dir_wdata;
    end
    if (dir_re) begin
      dir_rd_q <= dir_mem[dir_raddr];
    end
  end

  // Entry memory
  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (ent_re) begin
      ent_rd_q <= ent_mem[ent_raddr];
    end
  end

  assign busy     = step_q != S_IDLE;
  assign done_o   = done_q;
  assign status_o = status_q;

`ifndef SYNTHESIS
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after request transfer");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done_o high in two cycles in a row");

  a_total_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TOT_W'(TABLE_DEPTH))
    else $error("entry total beyond table depth");

  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == ST_FULL |-> total_q == TOT_W'(TABLE_DEPTH))
    else $error("full status with room in the table");
`endif

endmodule

`default_nettype wire
